// File: src/rbpf_pkg.sv
package rbpf_pkg;

	typedef struct packed {
		logic       mode;
		logic [9:0] pixel_index;
	} in_item_t;

	typedef struct packed {
		logic [9:0] out_pixel;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_item_t;

	// One pixel's stored state: color with red in the top byte.
	typedef struct packed {
		logic [23:0] color;
		logic        fading;
		logic [7:0]  timer;
		logic [7:0]  length;
	} pix_entry_t;

	localparam int PixWidth = $bits(pix_entry_t);

	localparam pix_entry_t PIX_RESET = '{color: 24'd0, fading: 1'b0, timer: 8'd0, length: 8'd1};

	typedef enum logic [1:0] {
		CFG_FADE_TIME  = 2'd0,
		CFG_PAUSE_TIME = 2'd1,
		CFG_PEAK_LEVEL = 2'd2,
		CFG_SEED       = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] SEED_MASK  = 32'hDEADBEEF;
	localparam logic [31:0] RAND_RESET = 32'd12345;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
		logic [15:0] remainder;
	} div_rsp_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] a;
		logic [31:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// File: src/rbpf_ram.sv
module rbpf_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rbpf_div.sv
module rbpf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rbpf_pkg::div_req_t req,
	output rbpf_pkg::div_rsp_t rsp
);
	import rbpf_pkg::*;

	// Restoring division, one quotient bit per cycle.
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], ge};
			rem_q <= ge ? diff[15:0] : trial[15:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: src/random_blink_pixel_fader_core.sv
// Random blink pixel fader. Each pixel holds a color, a fading or paused phase, a
// phase timer and a phase length, all in frames of 33 ms, in one single-port-write
// RAM of PIXEL_COUNT words. A stagger transfer (mode 0) places a pixel at a random
// point of its cycle and returns nothing; a stagger of pixel 0 first reseeds the
// shared xorshift32 generator from the seed register. An advance transfer (mode 1)
// returns the pixel's color scaled by a quadratic ease-out, or black while paused,
// and moves the pixel on by one frame. Items are handled one at a time. Every
// random draw below a bound other than 256, and the brightness quotient, go through
// one shared serial divider, so a paused pixel that stays paused is the quickest
// item, a fade that ends with a jittered pause, which needs two divisions, the
// slowest, and a stagger, a pause that ends in a new fade and a typical fading
// frame each need one division. After reset a clearing pass writes every RAM
// word, during which no input transfer is taken; configuration writes are taken
// at any time and should be made while the block is idle.
// Items whose pixel index is PIXEL_COUNT or more are taken and dropped.
module random_blink_pixel_fader_core #(
	parameter int PIXEL_COUNT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbpf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbpf_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata
);
	import rbpf_pkg::*;

	localparam int AW = PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1;

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_LOAD     = 13'b0000000000100,
		ST_DISPATCH = 13'b0000000001000,
		ST_DRAW     = 13'b0000000010000,
		ST_DIV_DRAW = 13'b0000000100000,
		ST_DRAWN    = 13'b0000001000000,
		ST_MUL_A    = 13'b0000010000000,
		ST_MUL_B    = 13'b0000100000000,
		ST_DIV_BR   = 13'b0001000000000,
		ST_SCALE    = 13'b0010000000000,
		ST_WRITE    = 13'b0100000000000,
		ST_OUTPUT   = 13'b1000000000000
	} state_t;

	// What the pending random draw is for.
	typedef enum logic [2:0] {
		KIND_STAG  = 3'b001,
		KIND_COLOR = 3'b010,
		KIND_JIT   = 3'b100
	} draw_kind_t;

	state_t     state_q;
	draw_kind_t kind_q;

	// Configuration registers.
	logic [11:0] fade_q;
	logic [11:0] pause_q;
	logic [7:0]  peak_q;
	logic [31:0] seed_q;

	// Frame counts derived from the configuration. Dividing by 33 is a multiply
	// by 993 and a shift of 15, exact for 12-bit millisecond values. The fade
	// jitter range is a fifth of the fade length, the pause range three tenths.
	logic [11:0] fade_ms;
	logic [21:0] ff_prod;
	logic [21:0] pf_prod;
	logic [14:0] v20_prod;
	logic [16:0] v30_prod;
	logic [6:0]  ff_q;
	logic [6:0]  pf_q;
	logic [4:0]  v20_q;
	logic [5:0]  v30_q;

	assign fade_ms  = (fade_q < 12'd200) ? 12'd200 : fade_q;
	assign ff_prod  = fade_ms * 10'd993;
	assign pf_prod  = pause_q * 10'd993;
	assign v20_prod = ff_q * 8'd205;
	assign v30_prod = pf_q * 10'd615;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q  <= 12'd1000;
			pause_q <= 12'd500;
			peak_q  <= 8'd200;
			seed_q  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_FADE_TIME:  fade_q  <= cfg_wdata[11:0];
				CFG_PAUSE_TIME: pause_q <= cfg_wdata[11:0];
				CFG_PEAK_LEVEL: peak_q  <= cfg_wdata[7:0];
				CFG_SEED:       seed_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ff_q  <= ff_prod[21:15];
		pf_q  <= pf_prod[21:15];
		v20_q <= v20_prod[14:10];
		v30_q <= v30_prod[16:11];
	end

	// Item and working registers.
	logic        mode_q;
	logic [9:0]  pix_q;
	pix_entry_t  ent_q;
	logic [31:0] rand_q;
	logic [7:0]  draw_r_q;
	logic [1:0]  ccnt_q;
	logic        jit_after_q;
	logic        end_q;
	logic [15:0] rr_q;
	logic [15:0] ll_q;
	logic [7:0]  br_q;
	logic [15:0] prod_q;
	logic [1:0]  scnt_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [AW-1:0] clr_q;
	logic        out_valid_q;
	out_item_t   out_q;

	// RAM ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	pix_entry_t    ram_wdata;
	logic          ram_re;
	pix_entry_t    ram_rdata;
	pix_entry_t    ld_entry;

	// Divider.
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        accept;
	logic        in_range;
	logic [31:0] rand_nxt;
	logic [31:0] reseed;
	logic [8:0]  t1;
	logic        phase_end;
	logic [7:0]  rem_frames;
	logic [7:0]  peak_eff;
	logic [6:0]  jit_v;
	logic [7:0]  bound;
	logic [7:0]  chan;
	logic [32:0] scaled_prod;
	logic [7:0]  scaled;
	logic [6:0]  jit_base;
	logic [9:0]  jit_len;
	logic [7:0]  pause_len;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = 32'(in_data.pixel_index) < PIXEL_COUNT;

	assign rand_nxt = xorshift32(rand_q);
	assign reseed   = ((seed_q ^ SEED_MASK) == 32'd0) ? 32'd1 : (seed_q ^ SEED_MASK);

	assign t1         = {1'b0, ent_q.timer} + 9'd1;
	assign phase_end  = t1 >= {1'b0, ent_q.length};
	assign rem_frames = (ent_q.length > ent_q.timer) ? (ent_q.length - ent_q.timer) : 8'd0;
	assign peak_eff   = (peak_q == 8'd0) ? 8'd1 : peak_q;
	assign pause_len  = (pf_q == 7'd0) ? 8'd1 : {1'b0, pf_q};

	// A jitter draw picks its range from the phase being entered.
	assign jit_v    = ent_q.fading ? {2'b0, v20_q} : {1'b0, v30_q};
	assign jit_base = ent_q.fading ? ff_q : pf_q;
	assign jit_len  = {3'b0, jit_base} + {2'b0, draw_r_q} - {3'b0, jit_v};
	assign bound    = (kind_q == KIND_STAG) ? ({1'b0, ff_q} + {1'b0, pf_q})
		: {jit_v, 1'b1};

	always_comb begin
		ld_entry = ram_rdata;
		if (ld_entry.length == 8'd0) begin
			ld_entry.length = 8'd1;
		end
	end

	always_comb begin
		unique case (scnt_q)
			2'd0:    chan = ent_q.color[23:16];
			2'd1:    chan = ent_q.color[15:8];
			default: chan = ent_q.color[7:0];
		endcase
	end

	// Division by 255 of a product of two bytes: multiply by 32897, shift by 23.
	assign scaled_prod = prod_q * 17'd32897;
	assign scaled      = scaled_prod[30:23];

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = rand_nxt;
		div_req.divisor  = {8'd0, bound};
		if (state_q == ST_MUL_B) begin
			div_req.start    = 1'b1;
			div_req.dividend = {8'd0, 24'(peak_eff) * 24'(rr_q)};
			div_req.divisor  = ll_q;
		end else if (state_q == ST_DRAW && kind_q != KIND_COLOR) begin
			div_req.start = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(pix_q);
		ram_wdata = ent_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = PIX_RESET;
		end else if (state_q == ST_WRITE) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = accept && in_range;

	// The result register fills from the output state and empties on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUTPUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			kind_q      <= KIND_STAG;
			clr_q       <= '0;
			rand_q      <= RAND_RESET;
			ccnt_q      <= '0;
			scnt_q      <= '0;
			jit_after_q <= 1'b0;
			end_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == PIXEL_COUNT - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					if (!mode_q) begin
						if (pix_q == 10'd0) begin
							rand_q <= reseed;
						end
						kind_q  <= KIND_STAG;
						state_q <= ST_DRAW;
					end else if (ent_q.fading) begin
						end_q   <= phase_end;
						state_q <= ST_MUL_A;
					end else if (phase_end) begin
						kind_q      <= KIND_COLOR;
						ccnt_q      <= '0;
						jit_after_q <= 1'b1;
						state_q     <= ST_DRAW;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_DRAW: begin
					rand_q <= rand_nxt;
					if (kind_q == KIND_COLOR) begin
						state_q <= ST_DRAWN;
					end else begin
						state_q <= ST_DIV_DRAW;
					end
				end
				ST_DIV_DRAW: begin
					if (div_rsp.done) begin
						state_q <= ST_DRAWN;
					end
				end
				ST_DRAWN: begin
					unique case (kind_q)
						KIND_STAG: begin
							if ({1'b0, draw_r_q} < {1'b0, pf_q}) begin
								state_q <= ST_WRITE;
							end else begin
								kind_q      <= KIND_COLOR;
								ccnt_q      <= '0;
								jit_after_q <= 1'b0;
								state_q     <= ST_DRAW;
							end
						end
						KIND_COLOR: begin
							ccnt_q <= ccnt_q + 2'd1;
							if (ccnt_q == 2'd2) begin
								if (jit_after_q) begin
									kind_q  <= KIND_JIT;
									state_q <= ST_DRAW;
								end else begin
									state_q <= ST_WRITE;
								end
							end else begin
								state_q <= ST_DRAW;
							end
						end
						default: begin
							state_q <= ST_WRITE;
						end
					endcase
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					state_q <= ST_DIV_BR;
				end
				ST_DIV_BR: begin
					if (div_rsp.done) begin
						scnt_q  <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					scnt_q <= scnt_q + 2'd1;
					if (scnt_q == 2'd3) begin
						if (end_q && pf_q != 7'd0 && v30_q != 6'd0) begin
							kind_q  <= KIND_JIT;
							state_q <= ST_DRAW;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					state_q <= mode_q ? ST_OUTPUT : ST_IDLE;
				end
				ST_OUTPUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= in_data.mode;
					pix_q  <= in_data.pixel_index;
				end
			end
			ST_LOAD: begin
				ent_q <= ld_entry;
			end
			ST_DISPATCH: begin
				red_q   <= 8'd0;
				green_q <= 8'd0;
				blue_q  <= 8'd0;
				if (mode_q && !ent_q.fading) begin
					if (phase_end) begin
						ent_q.fading <= 1'b1;
						ent_q.timer  <= 8'd0;
					end else begin
						ent_q.timer <= t1[7:0];
					end
				end
			end
			ST_DRAW: begin
				if (kind_q == KIND_COLOR) begin
					draw_r_q <= rand_nxt[7:0];
				end
			end
			ST_DIV_DRAW: begin
				if (div_rsp.done) begin
					draw_r_q <= div_rsp.remainder[7:0];
				end
			end
			ST_DRAWN: begin
				unique case (kind_q)
					KIND_STAG: begin
						if ({1'b0, draw_r_q} < {1'b0, pf_q}) begin
							ent_q.fading <= 1'b0;
							ent_q.timer  <= draw_r_q;
							ent_q.length <= pause_len;
						end else begin
							ent_q.fading <= 1'b1;
							ent_q.timer  <= draw_r_q - {1'b0, pf_q};
							ent_q.length <= {1'b0, ff_q};
						end
					end
					KIND_COLOR: begin
						ent_q.color <= {ent_q.color[15:0], draw_r_q};
					end
					default: begin
						ent_q.length <= (jit_len == 10'd0) ? 8'd1 : jit_len[7:0];
					end
				endcase
			end
			ST_MUL_A: begin
				rr_q <= rem_frames * rem_frames;
				ll_q <= ent_q.length * ent_q.length;
			end
			ST_DIV_BR: begin
				if (div_rsp.done) begin
					br_q <= div_rsp.quotient[7:0];
				end
			end
			ST_SCALE: begin
				prod_q <= chan * br_q;
				unique case (scnt_q)
					2'd1: red_q   <= scaled;
					2'd2: green_q <= scaled;
					2'd3: blue_q  <= scaled;
					default: ;
				endcase
				if (scnt_q == 2'd3) begin
					if (end_q) begin
						ent_q.fading <= 1'b0;
						ent_q.timer  <= 8'd0;
						ent_q.length <= (pf_q == 7'd0) ? 8'd1 : {1'b0, pf_q};
					end else begin
						ent_q.timer <= t1[7:0];
					end
				end
			end
			ST_OUTPUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.out_pixel <= pix_q;
					out_q.red       <= red_q;
					out_q.green     <= green_q;
					out_q.blue      <= blue_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rbpf_ram #(
		.WIDTH(PixWidth),
		.DEPTH(PIXEL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(AW'(in_data.pixel_index)),
		.rdata(ram_rdata)
	);

	rbpf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

endmodule

// File: src/rbpf_chk.sv
module rbpf_chk #(
	parameter int PIXEL_COUNT = 1024
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input rbpf_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input rbpf_pkg::out_item_t out_data
);
	import rbpf_pkg::*;

	// A result waiting for the consumer holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An in-range item keeps the block busy on the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (32'(in_data.pixel_index) < PIXEL_COUNT) |=> !in_ready)
		else $error("input taken again while an item is in work");

	// A new result only appears after the block was busy with its item.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

	// Results only name pixels that exist.
	a_pixel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.out_pixel) < PIXEL_COUNT)
		else $error("result for a pixel outside the array");

endmodule

bind random_blink_pixel_fader_core rbpf_chk #(
	.PIXEL_COUNT(PIXEL_COUNT)
) u_rbpf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the random blink pixel fader core.
// A driver always block feeds input transfers from a queue that the initial
// block fills phase by phase. A monitor always block accepts result transfers
// and compares them against colors that a local model of the pixel state and
// the shared xorshift generator has predicted when each input was accepted.
module tb;
	import rbpf_pkg::*;

	localparam int PixCount = 1024;
	localparam int StallLimit = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [31:0] cfg_wdata;

	random_blink_pixel_fader_core #(.PIXEL_COUNT(PixCount)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// Local copy of the pixel store, the generator and the registers.
	logic [23:0] mdl_color [PixCount];
	logic mdl_fading [PixCount];
	logic [7:0] mdl_timer [PixCount];
	logic [7:0] mdl_length [PixCount];
	logic [31:0] mdl_rand;
	logic [11:0] reg_fade;
	logic [11:0] reg_pause;
	logic [7:0] reg_peak;
	logic [31:0] reg_seed;

	in_item_t pending_items[$];
	out_item_t expected_colors[$];
	int error_count;
	int advances_sent;
	int colors_checked;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic logic [31:0] draw_below(input logic [31:0] bound);
		logic [31:0] x;
		if (bound == 0) begin
			return 0;
		end
		x = mdl_rand;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		mdl_rand = x;
		return x % bound;
	endfunction

	function automatic void pick_color(input int p);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = draw_below(256);
		g = draw_below(256);
		b = draw_below(256);
		mdl_color[p] = {r, g, b};
	endfunction

	// Phase length spread by pct percent around base, never below one frame.
	function automatic logic [31:0] spread_length(input logic [31:0] base, input int pct);
		int v;
		int len;
		v = base * pct / 100;
		if (v == 0) begin
			return base;
		end
		len = int'(base) + int'(draw_below(2 * v + 1)) - v;
		return (len < 1) ? 1 : len;
	endfunction

	// Applies one accepted transfer to the model and queues the color it yields.
	function automatic void advance_pixel(input in_item_t it);
		int p;
		logic [31:0] ff;
		logic [31:0] pf;
		logic [31:0] s;
		logic [31:0] t;
		logic [31:0] len;
		logic [31:0] peak;
		logic [31:0] rem;
		logic [31:0] br;
		out_item_t o;
		p = it.pixel_index;
		ff = ((reg_fade < 200) ? 200 : reg_fade) / 33;
		if (ff < 1) begin
			ff = 1;
		end
		pf = reg_pause / 33;
		if (p >= PixCount) begin
			return;
		end
		if (it.mode == 1'b0) begin
			if (p == 0) begin
				mdl_rand = reg_seed ^ SEED_MASK;
				if (mdl_rand == 0) begin
					mdl_rand = 1;
				end
			end
			s = draw_below(ff + pf);
			if (s < pf) begin
				mdl_fading[p] = 1'b0;
				mdl_timer[p] = s[7:0];
				mdl_length[p] = (pf > 0) ? pf[7:0] : 8'd1;
			end else begin
				mdl_fading[p] = 1'b1;
				mdl_timer[p] = 8'(s - pf);
				mdl_length[p] = ff[7:0];
				pick_color(p);
			end
			return;
		end
		o.out_pixel = it.pixel_index;
		t = mdl_timer[p];
		len = (mdl_length[p] == 0) ? 1 : mdl_length[p];
		if (mdl_fading[p]) begin
			peak = (reg_peak < 1) ? 1 : reg_peak;
			rem = (len > t) ? len - t : 0;
			br = peak * rem * rem / (len * len);
			o.red = 8'(mdl_color[p][23:16] * br / 255);
			o.green = 8'(mdl_color[p][15:8] * br / 255);
			o.blue = 8'(mdl_color[p][7:0] * br / 255);
			mdl_timer[p] = 8'(t + 1);
			if (t + 1 >= len) begin
				mdl_fading[p] = 1'b0;
				mdl_timer[p] = 0;
				mdl_length[p] = (pf > 0) ? 8'(spread_length(pf, 30)) : 8'd1;
			end
		end else begin
			o.red = 0;
			o.green = 0;
			o.blue = 0;
			mdl_timer[p] = 8'(t + 1);
			if (t + 1 >= len) begin
				pick_color(p);
				mdl_fading[p] = 1'b1;
				mdl_timer[p] = 0;
				mdl_length[p] = 8'(spread_length(ff, 20));
			end
		end
		expected_colors.push_back(o);
	endfunction

	// Driver: the valid stays up until the transfer happens, then the next item
	// may follow at once or after a random gap. The item being offered stays at
	// the front of the queue until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				advance_pixel(in_data);
				void'(pending_items.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest predicted color.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected result, pixel", out_data.out_pixel, -1);
				end else begin
					out_item_t e;
					e = expected_colors.pop_front();
					if (out_data.out_pixel !== e.out_pixel)
						report_mismatch("out_pixel", out_data.out_pixel, e.out_pixel);
					if (out_data.red !== e.red)
						report_mismatch("red", out_data.red, e.red);
					if (out_data.green !== e.green)
						report_mismatch("green", out_data.green, e.green);
					if (out_data.blue !== e.blue)
						report_mismatch("blue", out_data.blue, e.blue);
					colors_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: counts cycles without any transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > StallLimit) begin
			$display("Watchdog expired with %0d items pending", pending_items.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One register write; the enable is dropped again before the task returns.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FADE_TIME: reg_fade = val[11:0];
			CFG_PAUSE_TIME: reg_pause = val[11:0];
			CFG_PEAK_LEVEL: reg_peak = val[7:0];
			default: reg_seed = val;
		endcase
		@(posedge clk);
	endtask

	task automatic push_item(input logic m, input logic [9:0] p);
		in_item_t it;
		it.mode = m;
		it.pixel_index = p;
		pending_items.push_back(it);
		if (m) begin
			advances_sent++;
		end
	endtask

	// Waits until every item went through and every result came back, then
	// lets the longest item time pass so a trailing stagger has finished.
	task automatic drain;
		while (pending_items.size() > 0 || in_valid || expected_colors.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Random phase: mixes staggers and frame-by-frame advances of a small set of
	// pixels, with an occasional item of random mode and pixel, so whole fade and pause cycles are walked through.
	task automatic random_phase(input int n);
		int k;
		int base;
		for (k = 0; k < n; k++) begin
			base = $urandom_range(3) * 256;
			if ($urandom_range(99) < 8) begin
				push_item(1'($urandom_range(1)), 10'($urandom_range(1023)));
			end else if ($urandom_range(99) < 10) begin
				push_item(1'b0, ($urandom_range(3) == 0) ? 10'd0 : 10'(base + $urandom_range(7)));
			end else begin
				push_item(1'b1, 10'(base + $urandom_range(7)));
			end
		end
	endtask

	initial begin
		int i;
		error_count = 0;
		advances_sent = 0;
		colors_checked = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_idx = CFG_FADE_TIME;
		cfg_wdata = '0;
		for (i = 0; i < PixCount; i++) begin
			mdl_color[i] = 0;
			mdl_fading[i] = 1'b0;
			mdl_timer[i] = 0;
			mdl_length[i] = 1;
		end
		mdl_rand = RAND_RESET;
		reg_fade = 1000;
		reg_pause = 500;
		reg_peak = 200;
		reg_seed = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: advance from the reset state, the highest pixel index,
		// staggers of pixel 0 with a seed that reseeds to one, extreme
		// registers, short fades that end quickly and a zero pause.
		push_item(1'b1, 10'd0);
		push_item(1'b1, 10'd1023);
		push_item(1'b1, 10'd0);
		push_item(1'b1, 10'd1023);
		drain();
		write_reg(CFG_SEED, SEED_MASK);
		write_reg(CFG_FADE_TIME, 32'd0);
		write_reg(CFG_PAUSE_TIME, 32'd0);
		write_reg(CFG_PEAK_LEVEL, 32'd0);
		push_item(1'b0, 10'd0);
		push_item(1'b0, 10'd1023);
		for (i = 0; i < 8; i++)
			push_item(1'b1, (i % 2) ? 10'd1023 : 10'd0);
		drain();
		write_reg(CFG_FADE_TIME, 32'd4095);
		write_reg(CFG_PAUSE_TIME, 32'd4095);
		write_reg(CFG_PEAK_LEVEL, 32'd255);
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		push_item(1'b0, 10'd0);
		push_item(1'b0, 10'h155);
		push_item(1'b0, 10'h2AA);
		push_item(1'b1, 10'h155);
		push_item(1'b1, 10'h2AA);
		push_item(1'b1, 10'd0);
		drain();

		// Random phases under several settings and idling patterns.
		for (i = 0; i < 5; i++) begin
			case (i)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				3: begin send_idle_pct = 37; recv_stall_pct = 37; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			write_reg(CFG_FADE_TIME, (i == 4) ? 32'd4095 : $urandom_range(150, 700));
			write_reg(CFG_PAUSE_TIME, (i == 2) ? 32'd0 : $urandom_range(0, 400));
			write_reg(CFG_PEAK_LEVEL, (i == 1) ? 32'd1 : $urandom_range(255));
			write_reg(CFG_SEED, $urandom());
			random_phase(180);
			drain();
		end

		$display("Covered %0d advance items, %0d colors checked, under five idling",
			advances_sent, colors_checked);
		$display("and register settings including both extremes of every register.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
src/rbpf_pkg.sv
src/rbpf_ram.sv
src/rbpf_div.sv
src/random_blink_pixel_fader_core.sv
src/rbpf_chk.sv
sim/tb.sv
